FILE: rtl/core/hss_pkg.sv
// ============================================================================
// hss_pkg: shared constants and types of the heat stencil step block
// Widths, queue depths, register indexes and the records that travel from
// the front part through the operation queue to the back part and out.
// ============================================================================
package hss_pkg;

    // Grid geometry. Row and column positions are IDX_W bits wide; the
    // clamped grid dimension needs one bit more so that it can hold MAX_GRID.
    localparam int MAX_GRID  = 128;
    localparam int GRID_MIN  = 3;
    localparam int IDX_W     = $clog2(MAX_GRID);
    localparam int GRID_W    = IDX_W + 1;

    // Data and register widths.
    localparam int DATA_W    = 32;
    localparam int GAIN_W    = 16;
    localparam int SIZE_W    = 8;
    localparam int FRAC_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    // Arithmetic widths of the stencil datapath.
    localparam int SUM_W     = DATA_W + 1;
    localparam int LAP_W     = DATA_W + 3;
    localparam int GAIN_S_W  = GAIN_W + 1;
    localparam int PROD_W    = LAP_W + GAIN_S_W;
    localparam int Q_W       = PROD_W - FRAC_W;
    localparam int V_W       = Q_W + 1;

    // Queue geometry.
    localparam int OP_DEPTH    = 4;
    localparam int OP_PTR_W    = $clog2(OP_DEPTH);
    localparam int OP_CNT_W    = OP_PTR_W + 1;
    localparam int RES_DEPTH   = 16;
    localparam int RES_PTR_W   = $clog2(RES_DEPTH);
    localparam int RES_CNT_W   = RES_PTR_W + 1;
    localparam int BACK_STAGES = 4;
    localparam int BACK_CNT_W  = $clog2(BACK_STAGES + 1);

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSION_GAIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE      = 1'b1;
    localparam logic [GAIN_W-1:0]    GAIN_RESET         = 16'd16384;
    localparam logic [SIZE_W-1:0]    GRID_RESET         = 8'd101;

    // Saturation limits of a signed data word.
    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // One classified request handed from the front part to the back part.
    // It always yields the result for (row, col); when two is set it also
    // yields the border cell (row + 1, col) of the last row.
    typedef struct packed {
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [DATA_W-1:0] centre;
        logic signed [DATA_W-1:0] left;
        logic signed [DATA_W-1:0] right;
        logic signed [DATA_W-1:0] up;
        logic signed [DATA_W-1:0] down;
        logic                     interior;
        logic                     two;
        logic                     done;
    } op_t;

    // One result as it leaves the block.
    typedef struct packed {
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     done;
    } res_t;

    // The one or two results of one request, written to the result queue.
    typedef struct packed {
        logic valid;
        logic two;
        res_t first;
        res_t second;
    } res_pair_t;

endpackage

FILE: rtl/core/hss_ram.sv
// ============================================================================
// hss_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered and shows
// the old contents when both ports hit the same address in one cycle.
// ============================================================================
module hss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/hss_front.sv
// ============================================================================
// hss_front: raster tracking and row stores
// Takes cells, keeps the row and column counters, reads the two row stores
// and hands one classified request per emitting cell to the operation queue.
// ============================================================================
module hss_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic signed [hss_pkg::DATA_W-1:0] cell_value,
    input  logic                              grid_start,
    input  logic [hss_pkg::SIZE_W-1:0]        grid_size,
    input  logic [hss_pkg::OP_CNT_W-1:0]      op_count,
    output logic                              op_push,
    output hss_pkg::op_t                      op
);
    import hss_pkg::*;

    logic                     accept;
    logic [GRID_W-1:0]        dim;
    logic [GRID_W-1:0]        dim_m1;
    logic                     restart;
    logic [IDX_W-1:0]         cur_row;
    logic [IDX_W-1:0]         cur_col;
    logic [IDX_W-1:0]         rd_addr_right;
    logic                     last_row;
    logic                     last_col;

    logic [IDX_W-1:0]         row_reg;
    logic [IDX_W-1:0]         col_reg;
    logic [IDX_W-1:0]         row_next;
    logic [IDX_W-1:0]         col_next;

    logic                     s1_valid_reg;
    logic [IDX_W-1:0]         s1_row_reg;
    logic [IDX_W-1:0]         s1_col_reg;
    logic signed [DATA_W-1:0] s1_x_reg;
    logic                     s1_emit_reg;
    logic                     s1_interior_reg;
    logic                     s1_last_row_reg;
    logic                     s1_done_reg;

    logic                     hit_pair_reg;
    logic                     hit_mid_reg;
    logic [2*DATA_W-1:0]      byp_pair_reg;
    logic signed [DATA_W-1:0] byp_mid_reg;
    logic signed [DATA_W-1:0] prev_ce_reg;

    logic [2*DATA_W-1:0]      pair_q;
    logic [2*DATA_W-1:0]      pair_eff;
    logic [2*DATA_W-1:0]      wr_pair;
    logic [DATA_W-1:0]        mid_q;
    logic signed [DATA_W-1:0] mid_c;
    logic signed [DATA_W-1:0] up_c;
    logic signed [DATA_W-1:0] right_c;

    // Grid dimension clamped to the supported range.
    always_comb
    begin
        if (grid_size < SIZE_W'(GRID_MIN))
        begin
            dim = GRID_W'(GRID_MIN);
        end
        else if (grid_size > SIZE_W'(MAX_GRID))
        begin
            dim = GRID_W'(MAX_GRID);
        end
        else
        begin
            dim = GRID_W'(grid_size);
        end
    end

    assign dim_m1  = dim - 1'b1;
    assign full    = (op_count + OP_CNT_W'(s1_valid_reg)) >= OP_CNT_W'(OP_DEPTH);
    assign accept  = push && !full;

    // A grid start, or counters left beyond a shrunken grid, restart at 0,0.
    assign restart = grid_start || (GRID_W'(row_reg) >= dim) || (GRID_W'(col_reg) >= dim);
    assign cur_row = restart ? '0 : row_reg;
    assign cur_col = restart ? '0 : col_reg;
    assign last_row = (GRID_W'(cur_row) == dim_m1);
    assign last_col = (GRID_W'(cur_col) == dim_m1);
    assign rd_addr_right = cur_col + 1'b1;

    always_comb
    begin
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : cur_row + 1'b1;
        end
        else
        begin
            col_next = cur_col + 1'b1;
            row_next = cur_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_row_reg      <= cur_row;
            s1_col_reg      <= cur_col;
            s1_x_reg        <= cell_value;
            s1_emit_reg     <= (cur_row != '0);
            s1_interior_reg <= (cur_row > IDX_W'(1)) && (cur_col != '0) && !last_col;
            s1_last_row_reg <= last_row;
            s1_done_reg     <= last_row && last_col;
        end
        // The write of the cell in stage 1 lands in the stores in the same
        // cycle as the reads of the next cell; forward it when addresses meet.
        hit_pair_reg <= s1_valid_reg && (s1_col_reg == cur_col);
        hit_mid_reg  <= s1_valid_reg && (s1_col_reg == rd_addr_right);
        byp_pair_reg <= wr_pair;
        byp_mid_reg  <= s1_x_reg;
        if (s1_valid_reg)
        begin
            prev_ce_reg <= mid_c;
        end
    end

    // Store entry c holds {upper row, middle row}; a second copy of the middle
    // row serves the read of column c + 1 in the same cycle.
    hss_ram #(
        .WIDTH (2 * DATA_W),
        .DEPTH (MAX_GRID)
    ) u_pair_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (wr_pair),
        .raddr (cur_col),
        .rdata (pair_q)
    );

    hss_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_GRID)
    ) u_mid_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (s1_x_reg),
        .raddr (rd_addr_right),
        .rdata (mid_q)
    );

    assign pair_eff = hit_pair_reg ? byp_pair_reg : pair_q;
    assign up_c     = pair_eff[2*DATA_W-1:DATA_W];
    assign mid_c    = pair_eff[DATA_W-1:0];
    assign right_c  = hit_mid_reg ? byp_mid_reg : mid_q;
    assign wr_pair  = {mid_c, s1_x_reg};

    // The left neighbour is the centre of the previous cell of the same row.
    always_comb
    begin
        op.row      = s1_row_reg - 1'b1;
        op.col      = s1_col_reg;
        op.centre   = mid_c;
        op.left     = prev_ce_reg;
        op.right    = right_c;
        op.up       = up_c;
        op.down     = s1_x_reg;
        op.interior = s1_interior_reg;
        op.two      = s1_last_row_reg;
        op.done     = s1_done_reg;
    end

    assign op_push = s1_valid_reg && s1_emit_reg;

    a_start_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && grid_start) |=> (s1_valid_reg && s1_col_reg == '0 && s1_row_reg == '0))
        else $error("grid start did not restart the raster at the origin");

endmodule

FILE: rtl/core/hss_op_queue.sv
// ============================================================================
// hss_op_queue: request queue between front and back parts
// A short first-in first-out queue of classified requests.
// ============================================================================
module hss_op_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  hss_pkg::op_t                 op_in,
    input  logic                         pop,
    output hss_pkg::op_t                 op_out,
    output logic                         empty,
    output logic [hss_pkg::OP_CNT_W-1:0] count
);
    import hss_pkg::*;

    op_t                 mem_reg [OP_DEPTH];
    logic [OP_PTR_W-1:0] wr_ptr_reg;
    logic [OP_PTR_W-1:0] rd_ptr_reg;
    logic [OP_CNT_W-1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= op_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + OP_CNT_W'(push) - OP_CNT_W'(pop);
        end
    end

    assign op_out = mem_reg[rd_ptr_reg];
    assign empty  = (count_reg == '0);
    assign count  = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < OP_CNT_W'(OP_DEPTH)))
        else $error("request queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("request queue read while empty");

endmodule

FILE: rtl/core/hss_back.sv
// ============================================================================
// hss_back: stencil arithmetic
// Four-stage datapath: neighbour sums, Laplacian, gain product, then
// floor scaling, centre add and saturation into one or two results.
// ============================================================================
module hss_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          op_empty,
    input  hss_pkg::op_t                  op,
    output logic                          op_pop,
    input  logic [hss_pkg::GAIN_W-1:0]    gain,
    input  logic [hss_pkg::RES_CNT_W-1:0] res_count,
    output hss_pkg::res_pair_t            res_wr
);
    import hss_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [DATA_W-1:0] centre;
        logic signed [DATA_W-1:0] down;
        logic                     interior;
        logic                     two;
        logic                     done;
    } meta_t;

    localparam int NEED_W = RES_CNT_W + 1;

    logic [BACK_CNT_W-1:0]    inflight;
    logic [NEED_W-1:0]        need;
    logic signed [GAIN_S_W-1:0] gain_s;

    logic                     a_valid_reg;
    meta_t                    a_meta_reg;
    logic signed [SUM_W-1:0]  a_lr_reg;
    logic signed [SUM_W-1:0]  a_ud_reg;

    logic                     b_valid_reg;
    meta_t                    b_meta_reg;
    logic signed [LAP_W-1:0]  b_lap_reg;

    logic                     c_valid_reg;
    meta_t                    c_meta_reg;
    logic signed [PROD_W-1:0] c_prod_reg;

    logic                     d_valid_reg;
    res_pair_t                d_pair_reg;
    res_pair_t                d_pair_next;

    logic signed [Q_W-1:0]    scaled;
    logic signed [V_W-1:0]    sum_v;

    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [V_W-1:0] v);
        if (v > V_W'(DATA_MAX))
        begin
            sat_data = DATA_MAX;
        end
        else if (v < V_W'(DATA_MIN))
        begin
            sat_data = DATA_MIN;
        end
        else
        begin
            sat_data = v[DATA_W-1:0];
        end
    endfunction

    // Each request in flight may still add two results; only take a new
    // request when the result queue can hold all of them.
    assign inflight = BACK_CNT_W'(a_valid_reg) + BACK_CNT_W'(b_valid_reg)
                    + BACK_CNT_W'(c_valid_reg) + BACK_CNT_W'(d_valid_reg);
    assign need     = NEED_W'(res_count) + NEED_W'({inflight, 1'b0}) + NEED_W'(2);
    assign op_pop   = !op_empty && (need <= NEED_W'(RES_DEPTH));
    assign gain_s   = {1'b0, gain};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= op_pop;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_meta_reg.row      <= op.row;
        a_meta_reg.col      <= op.col;
        a_meta_reg.centre   <= op.centre;
        a_meta_reg.down     <= op.down;
        a_meta_reg.interior <= op.interior;
        a_meta_reg.two      <= op.two;
        a_meta_reg.done     <= op.done;
        a_lr_reg            <= SUM_W'(op.left) + SUM_W'(op.right);
        a_ud_reg            <= SUM_W'(op.up) + SUM_W'(op.down);

        b_meta_reg <= a_meta_reg;
        b_lap_reg  <= LAP_W'(a_lr_reg) + LAP_W'(a_ud_reg)
                    - (LAP_W'(a_meta_reg.centre) <<< 2);

        c_meta_reg <= b_meta_reg;
        c_prod_reg <= PROD_W'(b_lap_reg) * PROD_W'(gain_s);

        d_pair_reg <= d_pair_next;
    end

    // Dropping the low fraction bits of a signed product rounds toward
    // minus infinity.
    assign scaled = c_prod_reg[PROD_W-1:FRAC_W];
    assign sum_v  = V_W'(scaled) + V_W'(c_meta_reg.centre);

    always_comb
    begin
        d_pair_next.valid        = c_valid_reg;
        d_pair_next.two          = c_meta_reg.two;
        d_pair_next.first.row    = c_meta_reg.row;
        d_pair_next.first.col    = c_meta_reg.col;
        d_pair_next.first.value  = c_meta_reg.interior ? sat_data(sum_v) : c_meta_reg.centre;
        d_pair_next.first.last   = !c_meta_reg.two;
        d_pair_next.first.done   = 1'b0;
        d_pair_next.second.row   = c_meta_reg.row + 1'b1;
        d_pair_next.second.col   = c_meta_reg.col;
        d_pair_next.second.value = c_meta_reg.down;
        d_pair_next.second.last  = 1'b1;
        d_pair_next.second.done  = c_meta_reg.done;
    end

    always_comb
    begin
        res_wr       = d_pair_reg;
        res_wr.valid = d_valid_reg;
    end

endmodule

FILE: rtl/core/hss_res_queue.sv
// ============================================================================
// hss_res_queue: result queue
// Takes one or two results per cycle and hands out the oldest one.
// ============================================================================
module hss_res_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hss_pkg::res_pair_t            wr,
    input  logic                          pop,
    output hss_pkg::res_t                 head,
    output logic                          empty,
    output logic [hss_pkg::RES_CNT_W-1:0] count
);
    import hss_pkg::*;

    res_t                 mem_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg;
    logic [RES_PTR_W-1:0] rd_ptr_reg;
    logic [RES_CNT_W-1:0] count_reg;
    logic [RES_PTR_W-1:0] wr_ptr_inc;
    logic [RES_CNT_W-1:0] n_wr;
    logic                 take;

    assign wr_ptr_inc = wr_ptr_reg + 1'b1;
    assign take       = pop && !empty;

    always_comb
    begin
        if (!wr.valid)
        begin
            n_wr = '0;
        end
        else if (wr.two)
        begin
            n_wr = RES_CNT_W'(2);
        end
        else
        begin
            n_wr = RES_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.valid)
        begin
            mem_reg[wr_ptr_reg] <= wr.first;
            if (wr.two)
            begin
                mem_reg[wr_ptr_inc] <= wr.second;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + n_wr[RES_PTR_W-1:0];
            if (take)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + n_wr - RES_CNT_W'(take);
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

    a_room_for_pair: assert property (@(posedge clk) disable iff (!rst_n)
        wr.valid |-> (count_reg <= RES_CNT_W'(RES_DEPTH - 2)))
        else $error("result queue written without room for two results");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= RES_CNT_W'(RES_DEPTH))
        else $error("result queue count beyond its depth");

endmodule

FILE: rtl/core/heat_stencil_step_top.sv
// ============================================================================
// heat_stencil_step_top: one explicit step of the 2-D heat equation
// Five-point stencil over a square grid streamed in raster order, with two
// row stores, a decoupled arithmetic back end and a result queue.
// ============================================================================
//
// Channel   Direction  Handshake            Payload
// input     in         push / full          cell_value, grid_start
// results   out        empty / pop          row_index, col_index, new_value,
//                                           last_of_run, grid_done
// config    in         wr_en                wr_index, wr_data
//
// The block takes one cell per clock while full is low. The row stores are
// read at two columns in the cycle a cell is taken and written back in the
// next cycle, so cells may follow each other on every clock; results leave
// at one per clock while pop is high, which makes the result port the limit
// during the last row, where each cell gives two results. Reset clears the
// counters, the queues and loads the register defaults; the row stores are
// not cleared. full rises only when the request queue between front and
// back fills up, which happens when the result queue backs up, as with pop
// held low or during the last row.
//
module heat_stencil_step_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input requests.
    input  logic                                push,
    output logic                                full,
    input  logic signed [hss_pkg::DATA_W-1:0]   cell_value,
    input  logic                                grid_start,
    // Result requests.
    output logic                                empty,
    input  logic                                pop,
    output logic [hss_pkg::IDX_W-1:0]           row_index,
    output logic [hss_pkg::IDX_W-1:0]           col_index,
    output logic signed [hss_pkg::DATA_W-1:0]   new_value,
    output logic                                last_of_run,
    output logic                                grid_done,
    // Configuration writes.
    input  logic                                wr_en,
    input  logic [hss_pkg::CFG_IDX_W-1:0]       wr_index,
    input  logic [hss_pkg::CFG_W-1:0]           wr_data
);
    import hss_pkg::*;

    logic [GAIN_W-1:0]    gain_reg;
    logic [SIZE_W-1:0]    grid_size_reg;

    logic                 op_push;
    op_t                  op_front;
    op_t                  op_head;
    logic                 op_pop;
    logic                 op_empty;
    logic [OP_CNT_W-1:0]  op_count;

    res_pair_t            res_wr;
    res_t                 res_head;
    logic [RES_CNT_W-1:0] res_count;

    // Configuration registers. The user must change them only while idle; the
    // block does not enforce it. Front and back parts use them directly.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= GAIN_RESET;
            grid_size_reg <= GRID_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_DIFFUSION_GAIN:
                begin
                    gain_reg <= wr_data[GAIN_W-1:0];
                end
                CFG_GRID_SIZE:
                begin
                    grid_size_reg <= wr_data[SIZE_W-1:0];
                end
            endcase
        end
    end

    // Front part: counters, row stores and classification of each cell.
    hss_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cell_value (cell_value),
        .grid_start (grid_start),
        .grid_size  (grid_size_reg),
        .op_count   (op_count),
        .op_push    (op_push),
        .op         (op_front)
    );

    // The request queue lets the front keep taking cells while the back
    // waits for room in the result queue.
    hss_op_queue u_op_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (op_push),
        .op_in  (op_front),
        .pop    (op_pop),
        .op_out (op_head),
        .empty  (op_empty),
        .count  (op_count)
    );

    // Back part: the stencil arithmetic.
    hss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_empty  (op_empty),
        .op        (op_head),
        .op_pop    (op_pop),
        .gain      (gain_reg),
        .res_count (res_count),
        .res_wr    (res_wr)
    );

    // Result queue: the oldest result sits on the output ports.
    hss_res_queue u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res_wr),
        .pop   (pop),
        .head  (res_head),
        .empty (empty),
        .count (res_count)
    );

    assign row_index   = res_head.row;
    assign col_index   = res_head.col;
    assign new_value   = res_head.value;
    assign last_of_run = res_head.last;
    assign grid_done   = res_head.done;

endmodule
